// File: rtl/core/rsmp_pkg.sv
// ----------------------------------------------------------------------------
// Systematic resampler package
// Shared field widths, status codes and the command and status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsmp_pkg;

	localparam int OFFSET_W = 16;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;
	localparam int RATIO_W  = 16;
	localparam int STATUS_W = 2;
	localparam int QUOT_W   = RATIO_W + 1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NEG_WEIGHT = 2'd1,
		ST_BAD_TOTAL  = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic div_start;
		logic emit_err;
		logic read;
		logic mult;
		logic step;
		logic emit;
		logic advance;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic neg_weight;
		logic bad_total;
		logic div_done;
		logic below;
		logic out_done;
		logic out_last;
		logic out_pend;
	} sts_t;

endpackage

// File: rtl/core/rsmp_if.sv
// ----------------------------------------------------------------------------
// Systematic resampler channels
// Weight channel into the block and result channel out of it, each with
// valid, ready and the payload of one word.
// ----------------------------------------------------------------------------
interface rsmp_in_if #(parameter int WeightW = 32) ();
	logic                               valid;
	logic                               ready;
	logic signed [WeightW-1:0]          weight;
	logic                               last_weight;
	logic [rsmp_pkg::OFFSET_W-1:0]      random_offset;

	modport source (output valid, output weight, output last_weight,
		output random_offset, input ready);
	modport sink (input valid, input weight, input last_weight,
		input random_offset, output ready);
endinterface

interface rsmp_out_if ();
	logic                               valid;
	logic                               ready;
	logic [rsmp_pkg::INDEX_W-1:0]       particle_index;
	logic [rsmp_pkg::COUNT_W-1:0]       resample_count;
	logic [rsmp_pkg::COUNT_W-1:0]       unique_count;
	logic [rsmp_pkg::RATIO_W-1:0]       min_ratio;
	logic [rsmp_pkg::STATUS_W-1:0]      status;
	logic                               last_result;

	modport source (output valid, output particle_index, output resample_count,
		output unique_count, output min_ratio, output status, output last_result,
		input ready);
	modport sink (input valid, input particle_index, input resample_count,
		input unique_count, input min_ratio, input status, input last_result,
		output ready);
endinterface

// File: rtl/core/rsmp_div.sv
// ----------------------------------------------------------------------------
// Systematic resampler ratio divider
// Restoring divider, one quotient bit a cycle, giving the minimum weight over
// the total as a saturated Q0.16 fraction. Numerator must not exceed the
// denominator.
// ----------------------------------------------------------------------------
module rsmp_div #(
	parameter int DenW = 38
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [DenW-1:0]                num,
	input  logic [DenW-1:0]                den,
	output logic                           busy,
	output logic [rsmp_pkg::RATIO_W-1:0]   quot
);

	localparam int QuotW = rsmp_pkg::QUOT_W;
	localparam int StepW = $clog2(QuotW);

	logic                busy_q;
	logic [StepW-1:0]    step_q;
	logic [DenW-1:0]     rem_q;
	logic [QuotW-1:0]    q_q;
	logic [DenW:0]       trial;
	logic [DenW:0]       diff;
	logic                ge;

	assign trial = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign diff  = trial - {1'b0, den};
	assign ge    = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + StepW'(1);
			if (step_q == StepW'(QuotW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
			q_q   <= {q_q[QuotW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = q_q[QuotW-1] ? '1 : q_q[rsmp_pkg::RATIO_W-1:0];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && step_q != '0) |-> (rem_q < den))
		else $error("divider remainder not below denominator");

endmodule

// File: rtl/core/rsmp_dpath.sv
// ----------------------------------------------------------------------------
// Systematic resampler datapath
// Weight accumulation, cumulative store, grid walk by exact products, ratio
// divider and the result register.
// ----------------------------------------------------------------------------
module rsmp_dpath #(
	parameter int MaxP = 64,
	parameter int WB   = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [WB-1:0]             weight,
	input  logic [rsmp_pkg::OFFSET_W-1:0]    random_offset,
	input  rsmp_pkg::cmd_t                   cmd,
	output rsmp_pkg::sts_t                   sts,
	input  logic                             res_ready,
	output logic                             res_valid,
	output logic [rsmp_pkg::INDEX_W-1:0]     res_index,
	output logic [rsmp_pkg::COUNT_W-1:0]     res_count,
	output logic [rsmp_pkg::COUNT_W-1:0]     res_unique,
	output logic [rsmp_pkg::RATIO_W-1:0]     res_ratio,
	output logic [rsmp_pkg::STATUS_W-1:0]    res_status,
	output logic                             res_last
);

	localparam int OffW   = rsmp_pkg::OFFSET_W;
	localparam int IndexW = rsmp_pkg::INDEX_W;
	localparam int CountW = rsmp_pkg::COUNT_W;
	localparam int CntW   = $clog2(MaxP + 1);
	localparam int IdxW   = (MaxP > 1) ? $clog2(MaxP) : 1;
	localparam int TotW   = WB + CntW;
	localparam int MagW   = TotW - 1;
	localparam int RhsW   = MagW + CntW;
	localparam int ProdW  = RhsW + OffW;
	localparam int InitW  = MagW + OffW;
	localparam logic signed [WB-1:0] MinInit = {1'b0, {(WB-1){1'b1}}};
	localparam logic [CntW-1:0]      Full    = CntW'(MaxP);

	logic [CntW-1:0]           count_q;
	logic signed [TotW-1:0]    total_q;
	logic signed [WB-1:0]      min_q;
	logic [OffW-1:0]           u_q;
	logic [TotW-1:0]           cum_mem [MaxP];
	logic [TotW-1:0]           rd_q;
	logic [RhsW-1:0]           rhs_q;
	logic [ProdW-1:0]          lhs_q;
	logic [CntW-1:0]           k_q;
	logic [CntW-1:0]           cnt_q;
	logic [IdxW-1:0]           idx_q;
	logic [CntW-1:0]           uniq_q;

	logic                      res_valid_q;
	logic [IndexW-1:0]         res_index_q;
	logic [CountW-1:0]         res_count_q;
	logic [CountW-1:0]         res_unique_q;
	logic [rsmp_pkg::RATIO_W-1:0] res_ratio_q;
	rsmp_pkg::status_t         res_status_q;
	logic                      res_last_q;

	logic signed [TotW-1:0]    total_next;
	logic                      store_ok;
	logic [MagW-1:0]           tot_mag;
	logic [InitW-1:0]          lhs_init;
	logic                      below;
	logic                      is_last;
	logic [CntW-1:0]           uniq_next;
	logic                      div_busy;
	logic [rsmp_pkg::RATIO_W-1:0] quot;

	assign total_next = total_q + TotW'(weight);
	assign store_ok   = (count_q != Full);
	assign tot_mag    = total_q[MagW-1:0];
	assign lhs_init   = InitW'(u_q) * InitW'(tot_mag);
	assign below      = (k_q < count_q) && (lhs_q < {rhs_q, {OffW{1'b0}}});
	assign is_last    = ((CntW'(idx_q) + CntW'(1)) == count_q);
	assign uniq_next  = uniq_q + CntW'(cnt_q != '0);

	// set accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			min_q   <= MinInit;
		end else if (cmd.clear) begin
			count_q <= '0;
			total_q <= '0;
			min_q   <= MinInit;
		end else if (cmd.load && store_ok) begin
			count_q <= count_q + CntW'(1);
			total_q <= total_next;
			if (weight < min_q) begin
				min_q <= weight;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u_q <= random_offset;
		end
		if (cmd.load && store_ok) begin
			cum_mem[count_q[IdxW-1:0]] <= total_next;
		end
		if (cmd.read) begin
			rd_q <= cum_mem[idx_q];
		end
		if (cmd.mult) begin
			rhs_q <= RhsW'(rd_q[MagW-1:0]) * RhsW'(count_q);
		end
		if (cmd.setup) begin
			lhs_q <= ProdW'(lhs_init);
		end else if (cmd.step) begin
			lhs_q <= lhs_q + ProdW'({tot_mag, {OffW{1'b0}}});
		end
	end

	// grid walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			uniq_q <= '0;
		end else if (cmd.setup) begin
			k_q    <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			uniq_q <= '0;
		end else begin
			if (cmd.step) begin
				k_q   <= k_q + CntW'(1);
				cnt_q <= cnt_q + CntW'(1);
			end
			if (cmd.emit) begin
				uniq_q <= uniq_next;
			end
			if (cmd.advance) begin
				idx_q <= idx_q + IdxW'(1);
				cnt_q <= '0;
			end
		end
	end

	rsmp_div #(
		.DenW(MagW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (MagW'($unsigned(min_q))),
		.den   (tot_mag),
		.busy  (div_busy),
		.quot  (quot)
	);

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			res_index_q  <= '0;
			res_count_q  <= '0;
			res_unique_q <= '0;
			res_ratio_q  <= '0;
			res_status_q <= min_q[WB-1] ? rsmp_pkg::ST_NEG_WEIGHT
				: rsmp_pkg::ST_BAD_TOTAL;
			res_last_q   <= 1'b1;
		end else if (cmd.emit) begin
			res_index_q  <= IndexW'(idx_q);
			res_count_q  <= CountW'(cnt_q);
			res_unique_q <= is_last ? CountW'(uniq_next) : '0;
			res_ratio_q  <= is_last ? quot : '0;
			res_status_q <= rsmp_pkg::ST_OK;
			res_last_q   <= is_last;
		end
	end

	assign res_valid  = res_valid_q;
	assign res_index  = res_index_q;
	assign res_count  = res_count_q;
	assign res_unique = res_unique_q;
	assign res_ratio  = res_ratio_q;
	assign res_status = res_status_q;
	assign res_last   = res_last_q;

	always_comb begin
		sts            = '0;
		sts.neg_weight = min_q[WB-1];
		sts.bad_total  = total_q[TotW-1] || (total_q == '0);
		sts.div_done   = !div_busy;
		sts.below      = below;
		sts.out_done   = res_valid_q && res_ready;
		sts.out_last   = res_last_q;
		sts.out_pend   = res_valid_q;
	end

	a_grid_used_up: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && is_last) |-> (k_q == count_q))
		else $error("grid points left over at last particle");

	a_count_within_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (cnt_q <= k_q))
		else $error("particle count exceeds grid points walked");

	a_ratio_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_last_q && res_status_q == rsmp_pkg::ST_OK) |-> !div_busy)
		else $error("last result shown before ratio finished");

endmodule

// File: rtl/core/rsmp_ctrl.sv
// ----------------------------------------------------------------------------
// Systematic resampler controller
// Sequences loading, the total checks, the ratio division and the per
// particle read, multiply, walk and send steps.
// ----------------------------------------------------------------------------
module rsmp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	output rsmp_pkg::cmd_t   cmd,
	input  rsmp_pkg::sts_t   sts
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_DIV,
		S_READ,
		S_MULT,
		S_WALK,
		S_SEND
	} state_t;

	state_t state_q;
	logic   accept;
	logic   err;

	assign in_ready = (state_q == S_LOAD);
	assign accept   = in_valid && in_ready;
	assign err      = sts.neg_weight || sts.bad_total;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.setup     = (state_q == S_CHECK);
		cmd.div_start = (state_q == S_CHECK) && !err;
		cmd.emit_err  = (state_q == S_CHECK) && err;
		cmd.read      = (state_q == S_READ);
		cmd.mult      = (state_q == S_MULT);
		cmd.step      = (state_q == S_WALK) && sts.below;
		cmd.emit      = (state_q == S_WALK) && !sts.below;
		cmd.advance   = (state_q == S_SEND) && sts.out_done && !sts.out_last;
		cmd.clear     = (state_q == S_SEND) && sts.out_done && sts.out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept && in_last) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= err ? S_SEND : S_DIV;
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_MULT;
				end
				S_MULT: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (!sts.below) begin
						state_q <= S_SEND;
					end
				end
				S_SEND: begin
					if (sts.out_done) begin
						state_q <= sts.out_last ? S_LOAD : S_READ;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	a_pend_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		sts.out_pend |-> (state_q == S_SEND))
		else $error("result word pending outside send state");

	a_run_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> in_ready)
		else $error("weight channel not reopened after last result");

endmodule

// File: rtl/core/systematic_resampler_top.sv
// ----------------------------------------------------------------------------
// Systematic resampler
// Loads a set of particle weights and returns, per particle, how many copies
// a systematic resampling grid keeps, with unique count and minimum ratio.
// ----------------------------------------------------------------------------
// Usage:
//   weights: one word per particle weight, one per cycle while ready is high. The word with
//   last_weight set closes the set and carries the random offset. Words past
//   MAX_PARTICLES are dropped; ready stays low while a set is being resolved.
//   results: one word per loaded particle in index order, last_result on the
//   final one, which also carries unique_count and min_ratio. A negative
//   weight or a non-positive total gives a single word with the error status.
// Sequence after the last weight: a restoring divider for the ratio, then per
//   particle one store read, one multiply, one compare per grid point plus
//   one, and the send. An error word is registered from the check state that
//   follows the last weight.
// Reset clears the set; the cumulative store is not cleared. A stalled
//   receiver holds the result word and halts the walk until it is taken.
// ----------------------------------------------------------------------------
module systematic_resampler_top #(
	parameter int MAX_PARTICLES = 64,
	parameter int WEIGHT_BITS   = 32
) (
	input logic        clk,
	input logic        arst_n,
	rsmp_in_if.sink    weights,
	rsmp_out_if.source results
);

	rsmp_pkg::cmd_t cmd;
	rsmp_pkg::sts_t sts;
	logic           in_ready;

	rsmp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(weights.valid),
		.in_last (weights.last_weight),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	rsmp_dpath #(
		.MaxP(MAX_PARTICLES),
		.WB  (WEIGHT_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.weight       (weights.weight),
		.random_offset(weights.random_offset),
		.cmd          (cmd),
		.sts          (sts),
		.res_ready    (results.ready),
		.res_valid    (results.valid),
		.res_index    (results.particle_index),
		.res_count    (results.resample_count),
		.res_unique   (results.unique_count),
		.res_ratio    (results.min_ratio),
		.res_status   (results.status),
		.res_last     (results.last_result)
	);

	assign weights.ready = in_ready;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Systematic resampler testbench
// Sends sets of particle weights over the weight channel and checks every
// result word against a copy-count predictor kept in step with each accepted
// word. Covers directed extremes, both error statuses, an overfull set and a
// long random run under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_P       = 64;
	localparam int WEIGHT_W    = 32;
	localparam int WALK_CYCLES = 5 * MAX_P + 60;
	localparam int INDEX_W     = rsmp_pkg::INDEX_W;
	localparam int COUNT_W     = rsmp_pkg::COUNT_W;
	localparam int RATIO_W     = rsmp_pkg::RATIO_W;
	localparam int OFFSET_W    = rsmp_pkg::OFFSET_W;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  index;
		logic [COUNT_W-1:0]  count;
		logic [COUNT_W-1:0]  uniq;
		logic [RATIO_W-1:0]  ratio;
		rsmp_pkg::status_t   status;
		logic                last;
	} copy_word_t;

	logic clk = 1'b0;
	logic arst_n;

	rsmp_in_if #(.WeightW(WEIGHT_W)) weights_ch ();
	rsmp_out_if results_ch ();

	systematic_resampler_top #(
		.MAX_PARTICLES(MAX_P),
		.WEIGHT_BITS  (WEIGHT_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.weights(weights_ch),
		.results(results_ch)
	);

	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	copy_word_t  copies_due[$];
	longint      cum_sums[MAX_P];
	int unsigned set_size;
	longint      set_total;
	longint      set_min;

	int unsigned loaded_words;
	int unsigned sets_closed;
	int unsigned words_checked;
	int unsigned error_words;
	int unsigned mismatches;
	bit          failed;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_set();
		set_size  = 0;
		set_total = 0;
		set_min   = (64'sd1 <<< (WEIGHT_W - 1)) - 1;
	endfunction

	function automatic void predict_copies(logic signed [WEIGHT_W-1:0] w, logic lst,
		logic [OFFSET_W-1:0] off);
		u64_t        n;
		u64_t        k;
		u64_t        total;
		u64_t        cum;
		u64_t        cnt;
		u64_t        mw;
		u64_t        ratio;
		int unsigned uniq;
		copy_word_t  c;
		if (set_size < MAX_P) begin
			if (longint'(w) < set_min)
				set_min = longint'(w);
			set_total += longint'(w);
			cum_sums[set_size] = set_total;
			set_size++;
			loaded_words++;
		end
		if (!lst)
			return;
		sets_closed++;
		if (set_min < 0 || set_total <= 0) begin
			c = '0;
			c.status = (set_min < 0) ? rsmp_pkg::ST_NEG_WEIGHT : rsmp_pkg::ST_BAD_TOTAL;
			c.last = 1'b1;
			copies_due.push_back(c);
			clear_set();
			return;
		end
		n     = set_size;
		total = set_total;
		k     = 0;
		uniq  = 0;
		for (int i = 0; i < set_size; i++) begin
			cum = cum_sums[i];
			cnt = 0;
			// count grid points strictly below this cumulative weight
			while (k < n && ((k << 16) + off) * total < cum * (n << 16)) begin
				cnt++;
				k++;
			end
			if (cnt != 0)
				uniq++;
			c = '0;
			c.index  = INDEX_W'(i);
			c.count  = COUNT_W'(cnt);
			c.status = rsmp_pkg::ST_OK;
			if (i == set_size - 1) begin
				mw    = set_min;
				ratio = (mw << 16) / total;
				if (ratio > 65535)
					ratio = 65535;
				c.uniq  = COUNT_W'(uniq);
				c.ratio = RATIO_W'(ratio);
				c.last  = 1'b1;
			end
			copies_due.push_back(c);
		end
		clear_set();
	endfunction

	function automatic void report(string what, copy_word_t want, copy_word_t got);
		mismatches++;
		failed = 1'b1;
		if (mismatches <= 10) begin
			$display("%0t %s: want idx %0d cnt %0d uniq %0d ratio %0d status %0d last %0d;",
				$realtime, what, want.index, want.count, want.uniq, want.ratio,
				want.status, want.last);
			$display("    got idx %0d cnt %0d uniq %0d ratio %0d status %0d last %0d",
				got.index, got.count, got.uniq, got.ratio, got.status, got.last);
		end
	endfunction

	task automatic check_word();
		copy_word_t got;
		copy_word_t want;
		got.index  = results_ch.particle_index;
		got.count  = results_ch.resample_count;
		got.uniq   = results_ch.unique_count;
		got.ratio  = results_ch.min_ratio;
		got.status = rsmp_pkg::status_t'(results_ch.status);
		got.last   = results_ch.last_result;
		words_checked++;
		if (got.last && got.status != rsmp_pkg::ST_OK)
			error_words++;
		if (copies_due.size() == 0) begin
			report("word with none due", '0, got);
		end else begin
			want = copies_due.pop_front();
			if (got !== want)
				report("word mismatch", want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready)
			check_word();
	end

	always @(negedge clk) begin
		results_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	task automatic send_weight(logic signed [WEIGHT_W-1:0] w, logic lst,
		logic [OFFSET_W-1:0] off);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			weights_ch.valid <= 1'b0;
			@(negedge clk);
		end
		weights_ch.valid         <= 1'b1;
		weights_ch.weight        <= w;
		weights_ch.last_weight   <= lst;
		weights_ch.random_offset <= off;
		do
			@(posedge clk);
		while (!weights_ch.ready);
		predict_copies(w, lst, off);
	endtask

	function automatic logic signed [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(7))
			0:       return '0;
			1, 2, 3: return $urandom_range(1, 32'h0002_0000);
			4, 5:    return $urandom & 32'h7FFF_FFFF;
			default: return $urandom_range(1, 255);
		endcase
	endfunction

	task automatic test_extremes();
		send_weight(32'h0001_0000, 1'b1, 16'h0000);
		send_weight(32'h7FFF_FFFF, 1'b1, 16'hFFFF);
		for (int i = 0; i < 4; i++)
			send_weight(32'h0001_0000, i == 3, 16'h8000);
		send_weight(32'h0000_0000, 1'b0, 16'h0000);
		send_weight(32'h0005_0000, 1'b0, 16'h0000);
		send_weight(32'h0000_0000, 1'b0, 16'h0000);
		send_weight(32'h0000_0001, 1'b1, 16'hFFFF);
		send_weight(32'h0000_0001, 1'b0, 16'h0000);
		send_weight(32'h7FFF_FFFF, 1'b1, 16'h0000);
	endtask

	task automatic test_error_status();
		send_weight(32'h0001_0000, 1'b0, 16'h0000);
		send_weight(32'h8000_0000, 1'b0, 16'h0000);
		send_weight(32'h0002_0000, 1'b1, 16'h1234);
		send_weight(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		send_weight(32'h0000_0000, 1'b0, 16'h0000);
		send_weight(32'h0000_0000, 1'b1, 16'hA5A5);
		send_weight(32'h0000_0000, 1'b1, 16'h0000);
	endtask

	task automatic test_store_full();
		for (int i = 0; i < MAX_P; i++)
			send_weight(32'h7FFF_FFFF, 1'b0, 16'h0000);
		// drop: both words arrive past a full store
		send_weight(32'h8000_0000, 1'b0, 16'h0000);
		send_weight(32'h0000_0000, 1'b1, 16'h7FFF);
	endtask

	task automatic send_random_set();
		int unsigned size;
		int unsigned kind;
		int unsigned flaw_at;
		logic signed [WEIGHT_W-1:0] w;
		size    = ($urandom_range(19) == 0) ? $urandom_range(9, 70)
			: $urandom_range(1, 8);
		kind    = $urandom_range(99);
		flaw_at = $urandom_range(size - 1);
		for (int i = 0; i < size; i++) begin
			if (kind < 80)
				w = pick_weight();
			else if (kind < 88)
				w = (i == flaw_at) ? {1'b1, 31'($urandom)} : pick_weight();
			else if (kind < 94)
				w = '0;
			else
				w = $urandom;
			send_weight(w, i == size - 1, 16'($urandom));
		end
	endtask

	task automatic test_random(int unsigned src_pct, int unsigned snk_pct,
		int unsigned words);
		int unsigned target;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		target = loaded_words + words;
		while (loaded_words < target)
			send_random_set();
	endtask

	initial begin
		arst_n                   = 1'b0;
		weights_ch.valid         = 1'b0;
		weights_ch.weight        = '0;
		weights_ch.last_weight   = 1'b0;
		weights_ch.random_offset = '0;
		results_ch.ready         = 1'b0;
		src_idle_pct             = 0;
		snk_idle_pct             = 0;
		clear_set();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_error_status();
		src_idle_pct = 12;
		snk_idle_pct = 50;
		test_store_full();
		test_random(12, 50, 90);
		test_random(50, 12, 90);
		test_random(0, 0, 90);

		@(negedge clk);
		weights_ch.valid <= 1'b0;
		while (copies_due.size() != 0)
			@(posedge clk);
		repeat (WALK_CYCLES) @(posedge clk);

		$display("Covered %0d loaded weight words in %0d sets;", loaded_words, sets_closed);
		$display("%0d result words checked, %0d with error status, %0d mismatching.",
			words_checked, error_words, mismatches);
		if (!failed && copies_due.size() == 0)
			$display("systematic_resampler_top regression: pass");
		else
			$display("systematic_resampler_top regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timed out with %0d result words still due.", copies_due.size());
		$display("systematic_resampler_top regression: fail");
		$finish;
	end

endmodule
